@@ hdl/mexp_pkg.sv @@
package mexp_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int FIELD_WIDTH   = 32;
	localparam int PDATA_WIDTH   = 32;
	localparam int ADDR_WIDTH    = 3;

	// bits of the multiplier consumed per cycle of the modular multiplier
	localparam int DIGITS     = 2;
	localparam int STEPS      = (OPERAND_WIDTH + DIGITS - 1) / DIGITS;
	localparam int SCAN_WIDTH = STEPS * DIGITS;
	localparam int CNT_WIDTH  = $clog2(STEPS + 1);
	localparam int BIT_WIDTH  = $clog2(OPERAND_WIDTH);

	localparam logic [0:0] REG_EXPONENT = 1'b0;
	localparam logic [0:0] REG_MODULUS  = 1'b1;

	localparam logic [OPERAND_WIDTH-1:0] EXPONENT_RESET = OPERAND_WIDTH'(2);
	localparam logic [OPERAND_WIDTH-1:0] MODULUS_RESET  = OPERAND_WIDTH'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_RUN,
		ST_SQ_START,
		ST_SQ_RUN,
		ST_MUL_START,
		ST_MUL_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic                     start;
		logic [OPERAND_WIDTH-1:0] mult;
		logic [OPERAND_WIDTH-1:0] mcand;
	} mm_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic [OPERAND_WIDTH-1:0] prod;
	} mm_rsp_t;

	// one bit of interleaved modular multiplication: (2r + xbit*a) mod m, with r, a < m
	function automatic logic [OPERAND_WIDTH-1:0] mm_step(
		input logic [OPERAND_WIDTH-1:0] r,
		input logic                     xbit,
		input logic [OPERAND_WIDTH-1:0] a,
		input logic [OPERAND_WIDTH-1:0] m
	);
		logic [OPERAND_WIDTH+1:0] t;
		logic [OPERAND_WIDTH+1:0] mx;
		mx = {2'b00, m};
		t  = {1'b0, r, 1'b0} + (xbit ? {2'b00, a} : '0);
		if (t >= mx) begin
			t = t - mx;
		end
		if (t >= mx) begin
			t = t - mx;
		end
		return t[OPERAND_WIDTH-1:0];
	endfunction

endpackage

@@ hdl/mexp_mulmod.sv @@
module mexp_mulmod (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mexp_pkg::mm_req_t                      req,
	input  logic [mexp_pkg::OPERAND_WIDTH-1:0]     modulus,
	output mexp_pkg::mm_rsp_t                      rsp
);

	logic [mexp_pkg::OPERAND_WIDTH-1:0] r_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] y_q;
	logic [mexp_pkg::SCAN_WIDTH-1:0]    x_q;
	logic [mexp_pkg::CNT_WIDTH-1:0]     cnt_q;
	logic                               busy_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] r_nx;

	always_comb begin
		r_nx = r_q;
		for (int i = 0; i < mexp_pkg::DIGITS; i++) begin
			r_nx = mexp_pkg::mm_step(r_nx, x_q[mexp_pkg::SCAN_WIDTH-1-i], y_q, modulus);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= mexp_pkg::CNT_WIDTH'(mexp_pkg::STEPS);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == mexp_pkg::CNT_WIDTH'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			y_q <= req.mcand;
			x_q <= mexp_pkg::SCAN_WIDTH'(req.mult);
		end else if (busy_q) begin
			r_q <= r_nx;
			x_q <= x_q << mexp_pkg::DIGITS;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == mexp_pkg::CNT_WIDTH'(1));
	assign rsp.prod = r_nx;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("multiplier started while busy");

	a_prod_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (rsp.prod < modulus))
		else $error("product not reduced below modulus");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.done && !req.start) |=> !busy_q)
		else $error("multiplier still busy after last step");

endmodule

@@ hdl/mexp_ctrl.sv @@
module mexp_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [mexp_pkg::OPERAND_WIDTH-1:0]     base_w,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [mexp_pkg::OPERAND_WIDTH-1:0]     result,
	input  logic [mexp_pkg::OPERAND_WIDTH-1:0]     exponent,
	input  logic [mexp_pkg::OPERAND_WIDTH-1:0]     modulus,
	output mexp_pkg::mm_req_t                      req,
	input  mexp_pkg::mm_rsp_t                      rsp
);

	mexp_pkg::state_t state_q, state_nx;

	logic [mexp_pkg::OPERAND_WIDTH-1:0] acc_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] b_q;
	logic [mexp_pkg::BIT_WIDTH-1:0]     bit_q;
	logic                               out_valid_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] result_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] one_mod;
	logic                               in_xfer;
	logic                               out_free;

	assign one_mod  = (modulus == mexp_pkg::OPERAND_WIDTH'(1)) ? '0
		: mexp_pkg::OPERAND_WIDTH'(1);
	assign in_stall = (state_q != mexp_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		req.start = 1'b0;
		req.mult  = acc_q;
		req.mcand = acc_q;
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (modulus == '0) begin
						state_nx = mexp_pkg::ST_FIN;
					end else begin
						req.start = 1'b1;
						req.mult  = base_w;
						req.mcand = one_mod;
						state_nx  = mexp_pkg::ST_RED_RUN;
					end
				end
			end
			mexp_pkg::ST_RED_RUN: begin
				if (rsp.done) begin
					state_nx = mexp_pkg::ST_SQ_START;
				end
			end
			mexp_pkg::ST_SQ_START: begin
				req.start = 1'b1;
				state_nx  = mexp_pkg::ST_SQ_RUN;
			end
			mexp_pkg::ST_SQ_RUN: begin
				if (rsp.done) begin
					if (exponent[bit_q]) begin
						state_nx = mexp_pkg::ST_MUL_START;
					end else if (bit_q == '0) begin
						state_nx = mexp_pkg::ST_FIN;
					end else begin
						state_nx = mexp_pkg::ST_SQ_START;
					end
				end
			end
			mexp_pkg::ST_MUL_START: begin
				req.start = 1'b1;
				req.mcand = b_q;
				state_nx  = mexp_pkg::ST_MUL_RUN;
			end
			mexp_pkg::ST_MUL_RUN: begin
				if (rsp.done) begin
					state_nx = (bit_q == '0) ? mexp_pkg::ST_FIN : mexp_pkg::ST_SQ_START;
				end
			end
			mexp_pkg::ST_FIN: begin
				if (out_free) begin
					state_nx = mexp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			mexp_pkg::ST_IDLE: begin
				acc_q <= '0;
				bit_q <= mexp_pkg::BIT_WIDTH'(mexp_pkg::OPERAND_WIDTH - 1);
			end
			mexp_pkg::ST_RED_RUN: begin
				if (rsp.done) begin
					b_q   <= rsp.prod;
					acc_q <= one_mod;
				end
			end
			mexp_pkg::ST_SQ_RUN: begin
				if (rsp.done) begin
					acc_q <= rsp.prod;
					if (!exponent[bit_q] && bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
			mexp_pkg::ST_MUL_RUN: begin
				if (rsp.done) begin
					acc_q <= rsp.prod;
					if (bit_q != '0) begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register, free to take a new result once the pending one transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mexp_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mexp_pkg::ST_FIN && out_free) begin
			result_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !rsp.busy)
		else $error("multiply launched while unit busy");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::ST_SQ_START || state_q == mexp_pkg::ST_MUL_START)
		|-> (acc_q < modulus && b_q < modulus))
		else $error("operand not reduced below modulus");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mexp_pkg::ST_FIN && out_free) |=> out_valid_q)
		else $error("finished result not presented");

	a_mod_one_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && modulus == mexp_pkg::OPERAND_WIDTH'(1)) |-> (result_q == '0))
		else $error("nonzero result for modulus one");

endmodule

@@ hdl/modular_exponentiation.sv @@
// Modular exponentiation: power_mod = base ^ exponent mod modulus, one result per base.
//
// Setup: write exponent (offset 0x0) and modulus (offset 0x4) over the APB port
// while the block is idle; both keep their value for every following base.
// After reset exponent is 2 and modulus is 1, so every result is 0 until written.
// Input: a base transfers when in_valid is high and in_stall is low. in_stall
// stays high from that transfer until the result has moved to the output register.
// Output: power_mod transfers when out_valid is high and out_stall is low; a
// stalled result holds, and the next base is taken meanwhile.
// Sequence: the base is first reduced mod modulus, then one modular squaring per
// exponent bit plus one modular multiply per set bit, each in the shared
// 2-bit-per-cycle interleaved multiplier, and the result is then loaded into the
// output register. A modulus of 0 gives 0 without any multiply. The next base is
// taken in the cycle the result appears.
// Reset clears the sequencer and the output valid; registers return to reset values.
module modular_exponentiation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mexp_pkg::FIELD_WIDTH-1:0]     base,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mexp_pkg::FIELD_WIDTH-1:0]     power_mod,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mexp_pkg::ADDR_WIDTH-1:0]      paddr,
	input  logic [mexp_pkg::PDATA_WIDTH-1:0]     pwdata,
	output logic [mexp_pkg::PDATA_WIDTH-1:0]     prdata,
	output logic                                 pready
);

	logic [mexp_pkg::OPERAND_WIDTH-1:0] exponent_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] modulus_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] result;
	logic                               cfg_wr;
	logic [0:0]                         reg_sel;
	mexp_pkg::mm_req_t                  mm_req;
	mexp_pkg::mm_rsp_t                  mm_rsp;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= mexp_pkg::EXPONENT_RESET;
			modulus_q  <= mexp_pkg::MODULUS_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				mexp_pkg::REG_EXPONENT: exponent_q <= pwdata[mexp_pkg::OPERAND_WIDTH-1:0];
				mexp_pkg::REG_MODULUS:  modulus_q  <= pwdata[mexp_pkg::OPERAND_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mexp_pkg::REG_EXPONENT: prdata = mexp_pkg::PDATA_WIDTH'(exponent_q);
			mexp_pkg::REG_MODULUS:  prdata = mexp_pkg::PDATA_WIDTH'(modulus_q);
			default:                prdata = '0;
		endcase
	end

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.base_w    (base[mexp_pkg::OPERAND_WIDTH-1:0]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.exponent  (exponent_q),
		.modulus   (modulus_q),
		.req       (mm_req),
		.rsp       (mm_rsp)
	);

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mm_req),
		.modulus (modulus_q),
		.rsp     (mm_rsp)
	);

	assign power_mod = mexp_pkg::FIELD_WIDTH'(result);

endmodule

@@ verif/mexp_checker.sv @@
`timescale 1ns / 1ps

module mexp_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [mexp_pkg::FIELD_WIDTH-1:0]     base,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [mexp_pkg::FIELD_WIDTH-1:0]     power_mod,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic                                 pready,
	input  logic [mexp_pkg::ADDR_WIDTH-1:0]      paddr,
	input  logic [mexp_pkg::PDATA_WIDTH-1:0]     pwdata,
	output int                                   outstanding,
	output int                                   mismatches
);

	localparam int PRINT_CAP = 100;

	logic [mexp_pkg::OPERAND_WIDTH-1:0] exponent_q;
	logic [mexp_pkg::OPERAND_WIDTH-1:0] modulus_q;
	logic [mexp_pkg::FIELD_WIDTH-1:0]   expected_power_mod[$];
	logic [mexp_pkg::FIELD_WIDTH-1:0]   want;

	initial begin
		mismatches = 0;
	end

	// square-and-multiply from the top exponent bit, every intermediate below the modulus
	function automatic logic [mexp_pkg::FIELD_WIDTH-1:0] power_modulo(
		input logic [mexp_pkg::OPERAND_WIDTH-1:0] b,
		input logic [mexp_pkg::OPERAND_WIDTH-1:0] e,
		input logic [mexp_pkg::OPERAND_WIDTH-1:0] m
	);
		logic [63:0] acc;
		logic [63:0] reduced;
		logic [63:0] m64;
		if (m == '0) begin
			return '0;
		end
		m64 = 64'(m);
		reduced = 64'(b) % m64;
		acc = 64'(1) % m64;
		for (int i = mexp_pkg::OPERAND_WIDTH - 1; i >= 0; i--) begin
			acc = (acc * acc) % m64;
			if (e[i]) begin
				acc = (acc * reduced) % m64;
			end
		end
		return acc[mexp_pkg::FIELD_WIDTH-1:0];
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= mexp_pkg::EXPONENT_RESET;
			modulus_q <= mexp_pkg::MODULUS_RESET;
			expected_power_mod.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[mexp_pkg::ADDR_WIDTH-1:2])
					mexp_pkg::REG_EXPONENT: exponent_q <= pwdata[mexp_pkg::OPERAND_WIDTH-1:0];
					mexp_pkg::REG_MODULUS:  modulus_q <= pwdata[mexp_pkg::OPERAND_WIDTH-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_power_mod.push_back(
					power_modulo(base[mexp_pkg::OPERAND_WIDTH-1:0], exponent_q, modulus_q));
			end
			if (out_valid && !out_stall) begin
				if (expected_power_mod.size() == 0) begin
					report($sformatf("result %h with no base pending", power_mod));
				end else begin
					want = expected_power_mod.pop_front();
					if (power_mod !== want) begin
						report($sformatf("power_mod %h, expected %h (exponent %h modulus %h)",
							power_mod, want, exponent_q, modulus_q));
					end
				end
			end
			outstanding <= expected_power_mod.size();
		end
	end

endmodule

@@ verif/modular_exponentiation_tb.sv @@
`timescale 1ns / 1ps

module modular_exponentiation_tb;

	localparam int PERIOD          = 20;
	localparam int RESET_CYCLES    = 9;
	localparam int RANDOM_ITEMS    = 1500;
	localparam int PRESSURE_AT     = 40;
	localparam int PRESSURE_CYCLES = 3000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int LIMIT           = 8_000_000;

	logic                                 clk;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [mexp_pkg::FIELD_WIDTH-1:0]     base = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [mexp_pkg::FIELD_WIDTH-1:0]     power_mod;
	logic                                 psel = 1'b0;
	logic                                 penable = 1'b0;
	logic                                 pwrite = 1'b0;
	logic [mexp_pkg::ADDR_WIDTH-1:0]      paddr = '0;
	logic [mexp_pkg::PDATA_WIDTH-1:0]     pwdata = '0;
	logic [mexp_pkg::PDATA_WIDTH-1:0]     prdata;
	logic                                 pready;

	int outstanding;
	int mismatches;
	int tx_gap_max = 7;
	int rx_gap_max = 7;
	int bases_sent = 0;
	int results_taken = 0;
	int settings = 0;
	int cycles = 0;

	modular_exponentiation uut (.*);

	mexp_checker power_check (.*);

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// result side: random hold-off per transfer, one long hold-off to back up the block
	initial begin : receiver
		int hold;
		forever begin
			hold = (results_taken == PRESSURE_AT) ? PRESSURE_CYCLES
				: $urandom_range(0, rx_gap_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_taken++;
		end
	end

	task automatic send_base(input logic [mexp_pkg::FIELD_WIDTH-1:0] value);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		base <= value;
		do @(posedge clk); while (!(in_valid && !in_stall));
		bases_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [0:0] idx,
		input logic [mexp_pkg::PDATA_WIDTH-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= mexp_pkg::ADDR_WIDTH'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_key(input logic [31:0] e, input logic [31:0] m);
		wait_idle();
		reg_write(mexp_pkg::REG_EXPONENT, e);
		reg_write(mexp_pkg::REG_MODULUS, m);
		settings++;
	endtask

	function automatic logic [31:0] pick_exponent();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return 32'd1 << $urandom_range(0, 31);
			4: return $urandom_range(2, 16);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_modulus();
		case ($urandom_range(0, 7))
			0: return 32'd1;
			1: return $urandom_range(2, 3);
			2: return '1;
			3: return $urandom_range(2, 1000);
			4: return 32'h8000_0000 | $urandom;
			default: return $urandom_range(1, 32'hFFFF_FFFF);
		endcase
	endfunction

	function automatic logic [31:0] pick_base(input logic [31:0] m);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return m - 32'd1;
			3: return m;
			4: return $urandom_range(0, m - 32'd1);
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		logic [31:0] m;
		int n;
		int random_sent;
		random_sent = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values: everything reduces to zero
		send_base('0);
		send_base('1);
		send_base(32'd12345);
		// exponent zero
		apply_key(32'd0, 32'hFFFF_FFFF);
		send_base('0);
		send_base('1);
		send_base(32'd7);
		// exponent one, bases around the modulus
		apply_key(32'd1, 32'd1000);
		send_base('1);
		send_base(32'd999);
		send_base(32'd1000);
		send_base('0);
		// all-ones exponent and modulus
		apply_key('1, '1);
		send_base(32'hFFFF_FFFE);
		send_base(32'd2);
		send_base(32'h8000_0000);
		apply_key(32'd2, 32'hFFFF_FFFB);
		send_base(32'hFFFF_FFFA);
		// zero modulus
		apply_key(32'd65537, 32'd0);
		send_base(32'd5);
		send_base('1);
		// modulus one
		apply_key(32'd12345, 32'd1);
		send_base(32'd77);
		apply_key(32'd3, 32'd2);
		send_base(32'd3);
		send_base(32'd4);
		apply_key(32'd65537, 32'd3233);
		send_base(32'd65);
		send_base(32'd2790);

		while (random_sent < RANDOM_ITEMS) begin
			m = pick_modulus();
			tx_gap_max = $urandom_range(0, 1) ? 7 : 0;
			rx_gap_max = $urandom_range(0, 1) ? 7 : 0;
			apply_key(pick_exponent(), m);
			n = $urandom_range(60, 140);
			repeat (n) begin
				send_base(pick_base(m));
				random_sent++;
			end
		end
		wait_idle();

		$display("%0d bases checked under %0d key settings, exponents 0, 1 and all ones among them",
			bases_sent, settings);
		$display("moduli 0, 1, 2 and all ones, bases at and above the modulus, %0d-cycle hold-off",
			PRESSURE_CYCLES);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
